FILE: design/ffac_pkg.sv
// ----------------------------------------------------------------------------
// ffac_pkg
// Shared constants and elaboration-time table builders for the feedforward
// audio compressor: default widths, register map, reset values and the
// log2 / exp2 lookup table contents.
// ----------------------------------------------------------------------------
package ffac_pkg;

    // Default widths handed to the top level parameters.
    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int COEF_BITS_DEF       = 24;
    localparam int TABLE_ADDR_BITS_DEF = 6;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAKEUP    = 3'd4;

    localparam logic signed [15:0] THRESHOLD_RST = -16'sd5120;
    localparam logic [15:0]        RATIO_RST     = 16'd32768;
    localparam logic [23:0]        ATTACK_RST    = 24'd16739209;
    localparam logic [23:0]        RELEASE_RST   = 24'd16773412;
    localparam logic [15:0]        MAKEUP_RST    = 16'd4096;

    // 20*log10(2) in Q8.8 dB per Q16 octave, scaled by 2^24.
    localparam logic [18:0] DB_SCALE = 19'd394566;
    // log2(10)/20 in Q16 octaves per Q8.8 dB, scaled by 2^8.
    localparam logic [13:0] OCT_PER_DB = 14'd10885;

    // Table entry widths.
    localparam int LOG_W = 17;
    localparam int EXP_W = 31;

    // Integer square root of a 64-bit value, bit pair at a time.
    function automatic logic [63:0] f_isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (b > v) begin
                b = b >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 64'd0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Fractional log2 of (1 + i/2^t) in Q16, by repeated squaring.
    function automatic logic [LOG_W-1:0] f_log_entry(input int i, input int t);
        logic [63:0] x;
        logic [63:0] r;
        x = (64'(1 << t) + 64'(i)) << (30 - t);
        r = '0;
        for (int k = 0; k < 17; k++) begin
            x = (x * x) >> 30;
            r = r << 1;
            if (x >= (64'd1 << 31)) begin
                r = r | 64'd1;
                x = x >> 1;
            end
        end
        return LOG_W'((r + 64'd1) >> 1);
    endfunction

    // 2^(-i/2^t) in Q1.30, built from the 2^t-th root of one half.
    function automatic logic [EXP_W-1:0] f_exp_entry(input int i, input int t);
        logic [63:0] c;
        logic [63:0] e;
        c = 64'd1 << 29;
        for (int k = 0; k < 16; k++) begin
            if (k < t) begin
                c = f_isqrt64(c << 30);
            end
        end
        e = 64'd1 << 30;
        for (int j = 1; j <= i; j++) begin
            e = (e * c) >> 30;
        end
        return EXP_W'(e);
    endfunction

endpackage

FILE: design/feedforward_audio_compressor.sv
// Each sample is worked through the sequencer states in turn: envelope update, leading-zero
// normalization, log lookup, dB conversion, gain reduction, exp lookup, makeup gain and
// scaling, serialized by the single shared multiplier and one-step-per-cycle normalizer.
// A held output beat stalls only the final step; a new input is taken once it is stored.
// Synchronous active-low reset clears the envelope and the sequencer and sets the configuration
// registers to their default settings; the lookup tables are constants and need no fill.
// ----------------------------------------------------------------------------
// feedforward_audio_compressor
// Peak-envelope feedforward compressor. A small sequencer drives one signed
// multiplier through envelope update, dB conversion, gain reduction, makeup
// gain and sample scaling, with log2 / exp2 lookup tables and saturation.
// ----------------------------------------------------------------------------
module feedforward_audio_compressor #(
    parameter int SAMPLE_BITS     = ffac_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS       = ffac_pkg::COEF_BITS_DEF,
    parameter int TABLE_ADDR_BITS = ffac_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration writes.
    input  logic                                i_cfg_we,
    input  logic [ffac_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ffac_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input samples.
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_in,
    input  logic                                i_block_last,
    // Output samples.
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_sample_out,
    output logic                                o_clipped,
    output logic                                o_block_last_out
);
    import ffac_pkg::*;

    localparam int TSIZE     = 1 << TABLE_ADDR_BITS;
    localparam int LZ_W      = $clog2(SAMPLE_BITS);
    localparam int LZ_STEPS  = LZ_W;
    localparam int STEP_W    = $clog2(LZ_STEPS);
    localparam int MUL_W     = (SAMPLE_BITS + 2 > 26) ? SAMPLE_BITS + 2 : 26;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int L2_W      = LZ_W + 18;
    localparam int DB_W      = 18;
    localparam int OVER_W    = 19;
    localparam int ACC_W     = SAMPLE_BITS + 33;
    localparam int Q_W       = ACC_W - 28;
    localparam int CEFF_W    = 25;

    localparam longint unsigned EPS_RAW =
        ((64'd1 << (SAMPLE_BITS - 1)) + 64'd500000) / 64'd1000000;
    localparam logic [SAMPLE_BITS-1:0] EPS =
        (EPS_RAW == 0) ? SAMPLE_BITS'(1) : SAMPLE_BITS'(EPS_RAW);
    localparam logic [32:0] COEF_ONE = 33'(1) << COEF_BITS;
    localparam logic [32:0] HALF_C   = 33'(1) << (COEF_BITS - 1);
    localparam logic [Q_W-1:0] Q_HALF = Q_W'(1) << (SAMPLE_BITS - 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ENV_MUL  = 4'd1;
    localparam logic [3:0] S_ENV_UPD  = 4'd2;
    localparam logic [3:0] S_NORM     = 4'd3;
    localparam logic [3:0] S_LOG_RD   = 4'd4;
    localparam logic [3:0] S_DB_MUL   = 4'd5;
    localparam logic [3:0] S_DB_SUB   = 4'd6;
    localparam logic [3:0] S_OVER_MUL = 4'd7;
    localparam logic [3:0] S_RED_MUL  = 4'd8;
    localparam logic [3:0] S_EXP_RD   = 4'd9;
    localparam logic [3:0] S_GAIN_MUL = 4'd10;
    localparam logic [3:0] S_T_LO     = 4'd11;
    localparam logic [3:0] S_T_HI     = 4'd12;
    localparam logic [3:0] S_FINISH   = 4'd13;

    // Configuration registers.
    logic signed [15:0] r_threshold;
    logic [15:0]        r_ratio;
    logic [23:0]        r_attack;
    logic [23:0]        r_release;
    logic [15:0]        r_makeup;

    // Sequencer and datapath registers.
    logic [3:0]                 r_state;
    logic [3:0]                 n_state;
    logic [SAMPLE_BITS-1:0]     r_env;
    logic [SAMPLE_BITS-1:0]     r_mag;
    logic                       r_neg;
    logic                       r_last;
    logic [SAMPLE_BITS-1:0]     r_norm;
    logic [LZ_W-1:0]            r_lz;
    logic [STEP_W-1:0]          r_step;
    logic [LOG_W-1:0]           r_log;
    logic signed [OVER_W-1:0]   r_over;
    logic                       r_unity;
    logic [EXP_W-1:0]           r_exp;
    logic                       r_deep;
    logic [4:0]                 r_exp_sh;
    logic [15:0]                r_t_hi;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PROD_W-1:0]   r_acc;

    // Output register.
    logic                       r_out_valid;
    logic [SAMPLE_BITS-1:0]     r_sample_out;
    logic                       r_clipped;
    logic                       r_block_last_out;

    // Lookup tables, built at elaboration.
    logic [LOG_W-1:0] w_log_rom [TSIZE];
    logic [EXP_W-1:0] w_exp_rom [TSIZE];

    for (genvar g = 0; g < TSIZE; g++) begin : g_rom
        assign w_log_rom[g] = f_log_entry(g, TABLE_ADDR_BITS);
        assign w_exp_rom[g] = f_exp_entry(g, TABLE_ADDR_BITS);
    end

    // ------------------------------------------------------------------
    // Combinational helpers.
    // ------------------------------------------------------------------
    logic                          w_in_acc;
    logic [SAMPLE_BITS-1:0]        w_in_mag;
    logic [23:0]                   w_coef;
    logic [CEFF_W-1:0]             w_coef_eff;
    logic signed [SAMPLE_BITS:0]   w_env_diff;
    logic signed [PROD_W-1:0]      w_env_rnd;
    logic [SAMPLE_BITS-1:0]        w_env_new;
    logic [LZ_W-1:0]               w_norm_sh;
    logic                          w_top_zero;
    logic [TABLE_ADDR_BITS-1:0]    w_log_idx;
    logic signed [L2_W-1:0]        w_l2;
    logic signed [DB_W-1:0]        w_db;
    logic signed [OVER_W-1:0]      w_over;
    logic [31:0]                   w_rsum;
    logic [16:0]                   w_gain;
    logic signed [MUL_W-1:0]       w_mul_a;
    logic signed [MUL_W-1:0]       w_mul_b;
    logic signed [PROD_W-1:0]      w_prod;
    logic                          w_mul_en;
    logic [ACC_W-1:0]              w_total;
    logic [Q_W-1:0]                w_q;
    logic                          w_clip;
    logic [Q_W-1:0]                w_q_sat;
    logic                          w_out_free;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_in_mag   = i_sample_in[SAMPLE_BITS-1] ? -i_sample_in : i_sample_in;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Attack while the level rises above the envelope; clamp to one.
    assign w_coef     = (r_mag > r_env) ? r_attack : r_release;
    assign w_coef_eff = (33'(w_coef) > COEF_ONE) ? CEFF_W'(COEF_ONE) : CEFF_W'(w_coef);
    assign w_env_diff = $signed({1'b0, r_env}) - $signed({1'b0, r_mag});

    // env' = mag + floor((c*(env - mag) + half) / 2^COEF_BITS).
    assign w_env_rnd = (r_prod + $signed(PROD_W'(HALF_C))) >>> COEF_BITS;
    assign w_env_new = SAMPLE_BITS'(w_env_rnd + $signed(PROD_W'(r_mag)));

    // Leading-zero search, one power-of-two shift per cycle.
    assign w_norm_sh  = LZ_W'(1) << (STEP_W'(LZ_STEPS - 1) - r_step);
    assign w_top_zero = (r_norm >> (SAMPLE_BITS - int'(w_norm_sh))) == '0;
    assign w_log_idx  = r_norm[SAMPLE_BITS-2 -: TABLE_ADDR_BITS];

    // log2 in Q16 relative to full scale: table fraction minus the zero count.
    assign w_l2 = L2_W'($signed({1'b0, r_log})) - L2_W'($signed({1'b0, r_lz, 16'd0}));

    assign w_db   = $signed(r_prod[24 +: DB_W]);
    assign w_over = OVER_W'(w_db) - OVER_W'(r_threshold);

    // Reduction in Q16 octaves, rounded: integer part above bit 24, fraction below.
    assign w_rsum = r_prod[31:0] + 32'd128;

    always_comb begin
        if (r_unity) begin
            w_gain = 17'h10000;
        end else if (r_deep) begin
            w_gain = '0;
        end else begin
            w_gain = 17'(r_exp >> r_exp_sh);
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_mul_en = 1'b1;
        case (r_state)
            S_ENV_MUL: begin
                w_mul_a = MUL_W'($signed({1'b0, w_coef_eff}));
                w_mul_b = MUL_W'(w_env_diff);
            end
            S_DB_MUL: begin
                w_mul_a = MUL_W'(w_l2);
                w_mul_b = MUL_W'($signed({1'b0, DB_SCALE}));
            end
            S_OVER_MUL: begin
                w_mul_a = MUL_W'(r_over);
                w_mul_b = MUL_W'($signed({1'b0, r_ratio}));
            end
            S_RED_MUL: begin
                w_mul_a = MUL_W'($signed({1'b0, r_prod[16 +: 17]}));
                w_mul_b = MUL_W'($signed({1'b0, OCT_PER_DB}));
            end
            S_GAIN_MUL: begin
                w_mul_a = MUL_W'($signed({1'b0, w_gain}));
                w_mul_b = MUL_W'($signed({1'b0, r_makeup}));
            end
            S_T_LO: begin
                w_mul_a = MUL_W'($signed({1'b0, r_mag}));
                w_mul_b = MUL_W'($signed({1'b0, r_prod[16:0]}));
            end
            S_T_HI: begin
                w_mul_a = MUL_W'($signed({1'b0, r_mag}));
                w_mul_b = MUL_W'($signed({1'b0, r_t_hi}));
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // |sample| * gain * makeup, with the gain word split in two partial products.
    assign w_total = ACC_W'($unsigned(r_acc)) + (ACC_W'($unsigned(r_prod)) << 17)
                   + (ACC_W'(1) << 27);
    assign w_q     = w_total[ACC_W-1:28];
    assign w_clip  = r_neg ? (w_q > Q_HALF) : (w_q > Q_HALF - Q_W'(1));
    assign w_q_sat = w_clip ? (r_neg ? Q_HALF : Q_HALF - Q_W'(1)) : w_q;

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (w_in_acc) n_state = S_ENV_MUL;
            S_ENV_MUL:  n_state = S_ENV_UPD;
            S_ENV_UPD:  n_state = S_NORM;
            S_NORM:     if (r_step == STEP_W'(LZ_STEPS - 1)) n_state = S_LOG_RD;
            S_LOG_RD:   n_state = S_DB_MUL;
            S_DB_MUL:   n_state = S_DB_SUB;
            S_DB_SUB:   n_state = S_OVER_MUL;
            S_OVER_MUL: n_state = S_RED_MUL;
            S_RED_MUL:  n_state = S_EXP_RD;
            S_EXP_RD:   n_state = S_GAIN_MUL;
            S_GAIN_MUL: n_state = S_T_LO;
            S_T_LO:     n_state = S_T_HI;
            S_T_HI:     n_state = S_FINISH;
            S_FINISH:   if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_env       <= '0;
            r_out_valid <= 1'b0;
            r_threshold <= THRESHOLD_RST;
            r_ratio     <= RATIO_RST;
            r_attack    <= ATTACK_RST;
            r_release   <= RELEASE_RST;
            r_makeup    <= MAKEUP_RST;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_THRESHOLD: r_threshold <= $signed(i_cfg_data[15:0]);
                    REG_RATIO:     r_ratio     <= i_cfg_data[15:0];
                    REG_ATTACK:    r_attack    <= i_cfg_data[23:0];
                    REG_RELEASE:   r_release   <= i_cfg_data[23:0];
                    REG_MAKEUP:    r_makeup    <= i_cfg_data[15:0];
                    default:       ;
                endcase
            end

            if (r_state == S_ENV_UPD) begin
                r_env <= w_env_new;
            end

            if (r_state == S_FINISH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_prod;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_mag  <= w_in_mag;
                    r_neg  <= i_sample_in[SAMPLE_BITS-1];
                    r_last <= i_block_last;
                end
            end
            S_ENV_UPD: begin
                r_norm <= w_env_new + EPS;
                r_lz   <= '0;
                r_step <= '0;
            end
            S_NORM: begin
                if (w_top_zero) begin
                    r_norm <= r_norm << w_norm_sh;
                    r_lz   <= r_lz + w_norm_sh;
                end
                r_step <= r_step + STEP_W'(1);
            end
            S_LOG_RD: begin
                r_log <= w_log_rom[w_log_idx];
            end
            S_DB_SUB: begin
                r_over  <= w_over;
                r_unity <= w_over[OVER_W-1] || (w_over == '0);
            end
            S_EXP_RD: begin
                r_exp    <= w_exp_rom[w_rsum[23 -: TABLE_ADDR_BITS]];
                r_deep   <= w_rsum[31:24] > 8'd16;
                r_exp_sh <= 5'd14 + w_rsum[28:24];
            end
            S_T_LO: begin
                r_t_hi <= r_prod[32:17];
            end
            S_T_HI: begin
                r_acc <= r_prod;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    r_sample_out     <= r_neg ? SAMPLE_BITS'(-w_q_sat)
                                              : SAMPLE_BITS'(w_q_sat);
                    r_clipped        <= w_clip;
                    r_block_last_out <= r_last;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_sample_out     = $signed(r_sample_out);
    assign o_clipped        = r_clipped;
    assign o_block_last_out = r_block_last_out;

endmodule

FILE: design/ffac_checker.sv
// ----------------------------------------------------------------------------
// ffac_checker
// Port-level checks for the feedforward audio compressor, bound to the top.
// ----------------------------------------------------------------------------
module ffac_checker #(
    parameter int SAMPLE_BITS = ffac_pkg::SAMPLE_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS-1:0] o_sample_out,
    input logic                          o_clipped,
    input logic                          o_block_last_out
);
    import ffac_pkg::*;

    // A sample occupies the datapath after its beat, holding input ready low.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready ##1 !o_in_ready)
        else $error("input ready while a sample is in progress");

    // A result is stored exactly as the sequencer returns to idle.
    a_result_with_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $rose(o_in_ready))
        else $error("output appeared without the sequencer finishing");

    // A clipped beat carries one of the two full-scale codes.
    a_clip_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |->
            ((o_sample_out[SAMPLE_BITS-1] && (o_sample_out[SAMPLE_BITS-2:0] == '0)) ||
             (!o_sample_out[SAMPLE_BITS-1] && (&o_sample_out[SAMPLE_BITS-2:0]))))
        else $error("clipped flag set on a sample below full scale");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_sample_out) && $stable(o_clipped) &&
             $stable(o_block_last_out)))
        else $error("output beat changed while stalled");

endmodule

bind feedforward_audio_compressor ffac_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_ffac_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_sample_out     (o_sample_out),
    .o_clipped        (o_clipped),
    .o_block_last_out (o_block_last_out)
);
